// ----- rtl/vpa_pkg.sv -----
package vpa_pkg;

  localparam int MaxParts  = 32;
  localparam int SizeBits  = 16;
  localparam int OwnerBits = 8;
  localparam int CntBits   = $clog2(MaxParts + 1);
  localparam int IdxBits   = $clog2(MaxParts);

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic REG_MEMORY_SIZE = 1'b0;
  localparam logic REG_FIT_POLICY  = 1'b1;

  // One partition entry as held in a cell.
  typedef struct packed {
    logic [SizeBits-1:0]  start;
    logic [SizeBits-1:0]  length;
    logic                 used;
    logic [OwnerBits-1:0] owner;
  } part_t;

  // Operation broadcast to every cell for one cycle.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INIT,
    OP_SPLIT,
    OP_TAKE,
    OP_FREE,
    OP_MERGE
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [CntBits-1:0]   idx;
    logic [SizeBits-1:0]  size;
    logic [OwnerBits-1:0] owner;
  } cell_ctl_t;

endpackage

// ----- rtl/variable_partition_allocator_unit.sv -----
// Variable partition allocator: a chain of 32 partition cells kept in address
// order, with first, best or worst fit. One word is in work at a time. The
// partition count is at most 32. An allocate scans the chain one slot per
// cycle (stopping early under first fit), then splits or claims the chosen
// slot and offers its result; the next word is taken only once that result
// is accepted. A release scans the same way, frees every entry of the owner
// and then runs a merge pass over the table. A zero-size allocate is answered
// at once, without a scan. Writing memory_size reinitializes the table; write
// the configuration only between words.
module variable_partition_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [vpa_pkg::OwnerBits-1:0] in_owner_id,
  input  logic [vpa_pkg::SizeBits-1:0]  in_request_size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [vpa_pkg::SizeBits-1:0] out_start_address,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [vpa_pkg::SizeBits-1:0] cfg_wdata
);

  logic [vpa_pkg::SizeBits-1:0] mem_size_r;
  logic [1:0]                   fit_r;
  logic                         init_r;
  vpa_pkg::cell_ctl_t           ctl;
  vpa_pkg::part_t               parts [vpa_pkg::MaxParts];

  // Configuration registers; reset and size writes rebuild the table.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_size_r <= '1;
      fit_r      <= vpa_pkg::FIT_FIRST;
      init_r     <= 1'b1;
    end else begin
      init_r <= 1'b0;
      if (cfg_we && cfg_index == vpa_pkg::REG_MEMORY_SIZE) begin
        mem_size_r <= cfg_wdata;
        init_r     <= 1'b1;
      end
      if (cfg_we && cfg_index == vpa_pkg::REG_FIT_POLICY) fit_r <= cfg_wdata[1:0];
    end
  end

  vpa_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_command, .in_owner_id, .in_request_size,
    .out_valid, .out_ready, .out_status, .out_start_address,
    .cfg_init(init_r), .fit_policy(fit_r), .parts, .ctl
  );

  // The cell chain.
  for (genvar i = 0; i < vpa_pkg::MaxParts; i++) begin : g_cell
    vpa_cell u_cell (
      .clk,
      .pos(vpa_pkg::CntBits'(i)),
      .ctl,
      .left_i(parts[(i == 0) ? 0 : i - 1]),
      .right_i(parts[(i == vpa_pkg::MaxParts - 1) ? i : i + 1]),
      .init_len(mem_size_r),
      .part_o(parts[i])
    );
  end

endmodule

// ----- rtl/vpa_cell.sv -----
// One table slot. Slots shift right on a split and left on a merge, so every
// cell only talks to its two neighbors.
module vpa_cell (
  input  logic                clk,
  input  logic [vpa_pkg::CntBits-1:0] pos,
  input  vpa_pkg::cell_ctl_t  ctl,
  input  vpa_pkg::part_t      left_i,
  input  vpa_pkg::part_t      right_i,
  input  logic [vpa_pkg::SizeBits-1:0] init_len,
  output vpa_pkg::part_t      part_o
);

  vpa_pkg::part_t part_r;
  vpa_pkg::part_t part_nxt;

  // Next entry value for the broadcast operation.
  always_comb begin
    part_nxt = part_r;
    case (ctl.op)
      vpa_pkg::OP_INIT: begin
        part_nxt.start  = '0;
        part_nxt.length = init_len;
        part_nxt.used   = 1'b0;
        part_nxt.owner  = '0;
      end
      vpa_pkg::OP_SPLIT: begin
        if (pos == ctl.idx) begin
          part_nxt.used  = 1'b1;
          part_nxt.owner = ctl.owner;
          if (part_r.length != ctl.size) part_nxt.length = ctl.size;
        end else if (pos == ctl.idx + 1'b1) begin
          part_nxt.start  = left_i.start + ctl.size;
          part_nxt.length = left_i.length - ctl.size;
          part_nxt.used   = 1'b0;
          part_nxt.owner  = '0;
        end else if (pos > ctl.idx) begin
          part_nxt = left_i;
        end
      end
      // An exact fit only claims the slot; nothing moves.
      vpa_pkg::OP_TAKE: begin
        if (pos == ctl.idx) begin
          part_nxt.used  = 1'b1;
          part_nxt.owner = ctl.owner;
        end
      end
      vpa_pkg::OP_FREE: begin
        if (part_r.used && part_r.owner == ctl.owner) begin
          part_nxt.used  = 1'b0;
          part_nxt.owner = '0;
        end
      end
      vpa_pkg::OP_MERGE: begin
        if (pos == ctl.idx) part_nxt.length = part_r.length + right_i.length;
        else if (pos > ctl.idx) part_nxt = right_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    part_r <= part_nxt;
  end

  assign part_o = part_r;

endmodule

// ----- rtl/vpa_ctrl.sv -----
// Sequencer: scans the chain one slot per cycle, then issues one split, take
// or free operation to all cells, followed after a free by merge operations.
module vpa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_command,
  input  logic [vpa_pkg::OwnerBits-1:0] in_owner_id,
  input  logic [vpa_pkg::SizeBits-1:0]  in_request_size,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic [vpa_pkg::SizeBits-1:0] out_start_address,
  input  logic                cfg_init,
  input  logic [1:0]          fit_policy,
  input  vpa_pkg::part_t      parts [vpa_pkg::MaxParts],
  output vpa_pkg::cell_ctl_t  ctl
);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_APPLY, S_RSCAN, S_MERGE, S_DONE} state_t;

  state_t state_r;
  logic [vpa_pkg::CntBits-1:0]   count_r, k_r, pick_r;
  logic                          found_r, cmd_r;
  logic [vpa_pkg::OwnerBits-1:0] owner_r;
  logic [vpa_pkg::SizeBits-1:0]  size_r, best_r;
  logic [1:0]                    status_r;
  logic [vpa_pkg::SizeBits-1:0]  addr_r;
  vpa_pkg::part_t                cur, nxt;
  logic                          fits, better;
  logic                          split_need;

  // Slot under the scan pointer and its right neighbor.
  assign cur = parts[k_r[vpa_pkg::IdxBits-1:0]];
  assign nxt = parts[vpa_pkg::IdxBits'(k_r + 1'b1)];
  assign fits = !cur.used && cur.length >= size_r;
  // The chosen slot is longer than the request, so a remainder must be split off.
  assign split_need = parts[pick_r[vpa_pkg::IdxBits-1:0]].length != size_r;
  always_comb begin
    case (fit_policy)
      vpa_pkg::FIT_BEST:  better = cur.length < best_r;
      vpa_pkg::FIT_WORST: better = cur.length > best_r;
      default:            better = 1'b0;
    endcase
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = (state_r == S_DONE);
  assign out_status        = status_r;
  assign out_start_address = addr_r;

  // Cell command for this cycle.
  always_comb begin
    ctl       = '0;
    ctl.op    = vpa_pkg::OP_HOLD;
    ctl.idx   = pick_r;
    ctl.size  = size_r;
    ctl.owner = owner_r;
    if (cfg_init) ctl.op = vpa_pkg::OP_INIT;
    else if (state_r == S_APPLY) begin
      if (cmd_r) ctl.op = vpa_pkg::OP_FREE;
      else ctl.op = split_need ? vpa_pkg::OP_SPLIT : vpa_pkg::OP_TAKE;
    end else if (state_r == S_MERGE && k_r + 1'b1 < count_r && !cur.used && !nxt.used) begin
      ctl.op  = vpa_pkg::OP_MERGE;
      ctl.idx = k_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= vpa_pkg::CntBits'(1);
    end else begin
      if (cfg_init) count_r <= vpa_pkg::CntBits'(1);
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          cmd_r    <= in_command;
          owner_r  <= in_owner_id;
          size_r   <= in_request_size;
          k_r      <= '0;
          found_r  <= 1'b0;
          addr_r   <= '0;
          if (!in_command && in_request_size == '0) begin
            status_r <= vpa_pkg::ST_INVALID;
            state_r  <= S_DONE;
          end else begin
            state_r <= in_command ? S_RSCAN : S_SCAN;
          end
        end
        S_SCAN: begin
          if (k_r >= count_r) begin
            if (!found_r) begin
              status_r <= vpa_pkg::ST_NOFIT;
              state_r  <= S_DONE;
            end else if (split_need &&
                         count_r >= vpa_pkg::CntBits'(vpa_pkg::MaxParts)) begin
              status_r <= vpa_pkg::ST_FULL;
              state_r  <= S_DONE;
            end else begin
              state_r <= S_APPLY;
            end
          end else begin
            if (fits && (!found_r || better)) begin
              pick_r  <= k_r;
              best_r  <= cur.length;
              found_r <= 1'b1;
            end
            if (fits && !found_r && fit_policy != vpa_pkg::FIT_BEST &&
                fit_policy != vpa_pkg::FIT_WORST) k_r <= count_r;
            else k_r <= k_r + 1'b1;
          end
        end
        S_RSCAN: begin
          if (k_r >= count_r) begin
            if (found_r) state_r <= S_APPLY;
            else begin
              status_r <= vpa_pkg::ST_INVALID;
              state_r  <= S_DONE;
            end
          end else begin
            if (cur.used && cur.owner == owner_r) found_r <= 1'b1;
            k_r <= k_r + 1'b1;
          end
        end
        S_APPLY: begin
          status_r <= vpa_pkg::ST_OK;
          k_r      <= '0;
          if (cmd_r) state_r <= S_MERGE;
          else begin
            addr_r  <= parts[pick_r[vpa_pkg::IdxBits-1:0]].start;
            if (split_need) count_r <= count_r + 1'b1;
            state_r <= S_DONE;
          end
        end
        S_MERGE: begin
          if (k_r + 1'b1 >= count_r) state_r <= S_DONE;
          else if (!cur.used && !nxt.used) count_r <= count_r - 1'b1;
          else k_r <= k_r + 1'b1;
        end
        S_DONE: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // The table never holds more entries than slots, nor fewer than one.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= vpa_pkg::CntBits'(1) && count_r <= vpa_pkg::CntBits'(vpa_pkg::MaxParts))
    else $error("partition count out of range");
  // A refused allocate reports address zero.
  a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != vpa_pkg::ST_OK |-> out_start_address == '0)
    else $error("nonzero address on failure");
  // A split grows the table by at most one entry.
  a_split_one: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_APPLY && !cmd_r && !cfg_init |=> count_r - $past(count_r) <= 1)
    else $error("split grew table by more than one");

endmodule

// ----- tb/sv/tb.sv -----
module tb;

  localparam int NumRandom = 1800;

  // Expected status and address of one word on the result channel.
  typedef struct packed {
    logic [1:0]                   status;
    logic [vpa_pkg::SizeBits-1:0] addr;
  } grant_t;

  // Partition table model and the store of pending grants.
  class alloc_scoreboard;
    logic [vpa_pkg::SizeBits-1:0]  p_start [vpa_pkg::MaxParts];
    logic [vpa_pkg::SizeBits-1:0]  p_len   [vpa_pkg::MaxParts];
    logic                          p_used  [vpa_pkg::MaxParts];
    logic [vpa_pkg::OwnerBits-1:0] p_owner [vpa_pkg::MaxParts];
    int                            count;
    logic [vpa_pkg::SizeBits-1:0]  mem_size;
    logic [1:0]                    policy;
    grant_t                        pending[$];
    int                            errors;
    int                            checked;
    int                            n_ok, n_nofit, n_inval, n_full;

    function void init_table();
      for (int k = 0; k < vpa_pkg::MaxParts; k++) begin
        p_start[k] = '0;
        p_len[k] = '0;
        p_used[k] = 1'b0;
        p_owner[k] = '0;
      end
      p_len[0] = mem_size;
      count = 1;
    endfunction

    function void reset_state();
      mem_size = 16'hFFFF;
      policy = vpa_pkg::FIT_FIRST;
      init_table();
    endfunction

    function void write_reg(logic idx, logic [vpa_pkg::SizeBits-1:0] val);
      if (idx == vpa_pkg::REG_MEMORY_SIZE) begin
        mem_size = val;
        init_table();
      end else begin
        policy = val[1:0];
      end
    endfunction

    function grant_t allocate(logic [vpa_pkg::SizeBits-1:0] sz,
                              logic [vpa_pkg::OwnerBits-1:0] own);
      grant_t g;
      int pick;
      bit found;
      g = '0;
      pick = 0;
      found = 0;
      if (sz == 0) begin
        g.status = vpa_pkg::ST_INVALID;
        return g;
      end
      for (int k = 0; k < count; k++) begin
        if (!p_used[k] && p_len[k] >= sz) begin
          if (!found) begin
            pick = k;
            found = 1;
            if (policy != vpa_pkg::FIT_BEST && policy != vpa_pkg::FIT_WORST) break;
          end else if (policy == vpa_pkg::FIT_BEST && p_len[k] < p_len[pick]) begin
            pick = k;
          end else if (policy == vpa_pkg::FIT_WORST && p_len[k] > p_len[pick]) begin
            pick = k;
          end
        end
      end
      if (!found) begin
        g.status = vpa_pkg::ST_NOFIT;
        return g;
      end
      if (p_len[pick] > sz) begin
        if (count >= vpa_pkg::MaxParts) begin
          g.status = vpa_pkg::ST_FULL;
          return g;
        end
        for (int k = count; k > pick + 1; k--) begin
          p_start[k] = p_start[k-1];
          p_len[k] = p_len[k-1];
          p_used[k] = p_used[k-1];
          p_owner[k] = p_owner[k-1];
        end
        p_start[pick+1] = p_start[pick] + sz;
        p_len[pick+1] = p_len[pick] - sz;
        p_used[pick+1] = 1'b0;
        p_owner[pick+1] = '0;
        count++;
        p_len[pick] = sz;
      end
      p_used[pick] = 1'b1;
      p_owner[pick] = own;
      g.status = vpa_pkg::ST_OK;
      g.addr = p_start[pick];
      return g;
    endfunction

    function grant_t release_owner(logic [vpa_pkg::OwnerBits-1:0] own);
      grant_t g;
      bit found;
      int k;
      g = '0;
      found = 0;
      for (k = 0; k < count; k++) begin
        if (p_used[k] && p_owner[k] == own) begin
          p_used[k] = 1'b0;
          p_owner[k] = '0;
          found = 1;
        end
      end
      if (!found) begin
        g.status = vpa_pkg::ST_INVALID;
        return g;
      end
      // Fold each free neighbor into the free entry in front of it.
      k = 0;
      while (k + 1 < count) begin
        if (!p_used[k] && !p_used[k+1]) begin
          p_len[k] = p_len[k] + p_len[k+1];
          for (int j = k + 1; j + 1 < count; j++) begin
            p_start[j] = p_start[j+1];
            p_len[j] = p_len[j+1];
            p_used[j] = p_used[j+1];
            p_owner[j] = p_owner[j+1];
          end
          count--;
        end else begin
          k++;
        end
      end
      g.status = vpa_pkg::ST_OK;
      return g;
    endfunction

    function void note_request(logic cmd, logic [vpa_pkg::OwnerBits-1:0] own,
                               logic [vpa_pkg::SizeBits-1:0] sz);
      grant_t g;
      g = (cmd == 1'b0) ? allocate(sz, own) : release_owner(own);
      case (g.status)
        vpa_pkg::ST_OK: n_ok++;
        vpa_pkg::ST_NOFIT: n_nofit++;
        vpa_pkg::ST_INVALID: n_inval++;
        default: n_full++;
      endcase
      pending.push_back(g);
    endfunction

    function void check_grant(logic [1:0] st, logic [vpa_pkg::SizeBits-1:0] addr);
      grant_t g;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected word: status %0d addr %0d", st, addr);
        return;
      end
      g = pending.pop_front();
      if (g.status !== st || g.addr !== addr) begin
        errors++;
        if (errors <= 10)
          $display("Word %0d: expected status %0d addr %0d, got status %0d addr %0d",
                   checked, g.status, g.addr, st, addr);
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          in_command = 1'b0;
  logic [vpa_pkg::OwnerBits-1:0] in_owner_id = '0;
  logic [vpa_pkg::SizeBits-1:0]  in_request_size = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [1:0]                    out_status;
  logic [vpa_pkg::SizeBits-1:0]  out_start_address;
  logic                          cfg_we = 1'b0;
  logic                          cfg_index = 1'b0;
  logic [vpa_pkg::SizeBits-1:0]  cfg_wdata = '0;

  alloc_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always #6 clk = ~clk;

  variable_partition_allocator_unit DUT (.*);

  // Result side: random stalls and the check of each accepted word.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_grant(out_status, out_start_address);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one word and hold it until accepted; the model notes it at that edge.
  // Valid stays high afterwards until the next word, an idle cycle or a drain.
  task automatic send_word(logic cmd, logic [vpa_pkg::OwnerBits-1:0] own,
                           logic [vpa_pkg::SizeBits-1:0] sz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_owner_id <= own;
    in_request_size <= sz;
    do @(posedge clk); while (!in_ready);
    sb.note_request(cmd, own, sz);
  endtask

  // Drop valid and wait until every grant is back.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [vpa_pkg::SizeBits-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // Mostly plausible sizes against a few owners, with some extremes mixed in.
  task automatic random_word();
    logic [vpa_pkg::SizeBits-1:0]  sz;
    logic [vpa_pkg::OwnerBits-1:0] own;
    int r;
    r = $urandom_range(99);
    if (r < 3) sz = '0;
    else if (r < 8) sz = '1;
    else if (r < 20) sz = vpa_pkg::SizeBits'($urandom);
    else sz = vpa_pkg::SizeBits'($urandom_range(1, (sb.mem_size >> 3) + 2));
    own = vpa_pkg::OwnerBits'($urandom_range(0, 9));
    if ($urandom_range(9) == 0) own = own | 8'hF0;
    if ($urandom_range(99) < 25) send_word(1'b1, own, vpa_pkg::SizeBits'($urandom));
    else send_word(1'b0, own, sz);
  endtask

  initial begin
    logic [vpa_pkg::SizeBits-1:0] msz;
    sb.reset_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, each status, exact fit, full table.
    send_word(1'b0, 8'd1, 16'd0);
    send_word(1'b0, 8'hFF, 16'hFFFF);
    send_word(1'b0, 8'd2, 16'd1);
    send_word(1'b1, 8'd3, 16'hFFFF);
    send_word(1'b1, 8'hFF, 16'd0);
    send_word(1'b0, 8'd4, 16'hFFFF);
    write_reg(vpa_pkg::REG_MEMORY_SIZE, 16'd40);
    for (int k = 0; k < 33; k++) send_word(1'b0, k[7:0], 16'd1);
    send_word(1'b0, 8'd9, 16'd8);
    send_word(1'b1, 8'd5, 16'd0);
    send_word(1'b1, 8'd6, 16'd0);
    write_reg(vpa_pkg::REG_FIT_POLICY, vpa_pkg::SizeBits'(vpa_pkg::FIT_BEST));
    send_word(1'b0, 8'd7, 16'd1);
    write_reg(vpa_pkg::REG_FIT_POLICY, vpa_pkg::SizeBits'(vpa_pkg::FIT_WORST));
    send_word(1'b0, 8'd7, 16'd1);
    write_reg(vpa_pkg::REG_MEMORY_SIZE, 16'd1);
    send_word(1'b0, 8'd1, 16'd1);
    send_word(1'b0, 8'd1, 16'd1);

    // Random phases across policies, memory sizes and idling patterns.
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(vpa_pkg::REG_FIT_POLICY, vpa_pkg::SizeBits'(ph % 4));
      if (ph % 3 == 0) msz = 16'hFFFF;
      else if (ph % 3 == 1) msz = vpa_pkg::SizeBits'(1 + $urandom_range(200));
      else msz = vpa_pkg::SizeBits'($urandom);
      write_reg(vpa_pkg::REG_MEMORY_SIZE, msz);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      for (int i = 0; i < NumRandom / 12; i++) begin
        if (i == 70) drain();
        random_word();
      end
    end

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Checked %0d words: %0d granted, %0d no fit, %0d invalid, %0d table full.",
             sb.checked, sb.n_ok, sb.n_nofit, sb.n_inval, sb.n_full);
    if (sb.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #20000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- variable_partition_allocator_unit.f -----
rtl/vpa_pkg.sv
rtl/vpa_cell.sv
rtl/vpa_ctrl.sv
rtl/variable_partition_allocator_unit.sv
tb/sv/tb.sv
